@@ rtl/bba_pkg.sv @@
// Shared types and constants of the buddy bitmap allocator.
package bba_pkg;

  localparam int unsigned MaxLevels   = 10;
  localparam int unsigned TreeNodes   = (1 << MaxLevels) - 1;
  localparam int unsigned NodeW       = MaxLevels;
  localparam int unsigned HeaderBytes = 4;
  localparam int unsigned MinLeaf     = 8;
  localparam int unsigned MaxLeaf     = 65536;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_BIG  = 2'd1,
    ST_NO_MEM   = 2'd2,
    ST_NOT_BUSY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_LEVELS   = 2'd0,
    REG_MIN_BLK  = 2'd1,
    REG_POOL     = 2'd2,
    REG_RESERVED = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [3:0]  levels_in_use;
    logic [16:0] min_block_bytes;
    logic [25:0] pool_bytes;
  } cfg_t;

endpackage

@@ rtl/bba_cfg_regs.sv @@
// APB configuration registers of the buddy bitmap allocator.
module bba_cfg_regs (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  output bba_pkg::cfg_t cfg_o
);

  bba_pkg::cfg_t    cfg_q;
  bba_pkg::reg_idx_e idx;
  logic             wr;

  assign pready = 1'b1;
  assign idx    = bba_pkg::reg_idx_e'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.levels_in_use   <= 4'd5;
      cfg_q.min_block_bytes <= 17'd8;
      cfg_q.pool_bytes      <= 26'd256;
    end else if (wr) begin
      unique case (idx)
        bba_pkg::REG_LEVELS:   cfg_q.levels_in_use   <= pwdata[3:0];
        bba_pkg::REG_MIN_BLK:  cfg_q.min_block_bytes <= pwdata[16:0];
        bba_pkg::REG_POOL:     cfg_q.pool_bytes      <= pwdata[25:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bba_pkg::REG_LEVELS:  prdata = {28'd0, cfg_q.levels_in_use};
      bba_pkg::REG_MIN_BLK: prdata = {15'd0, cfg_q.min_block_bytes};
      bba_pkg::REG_POOL:    prdata = {6'd0, cfg_q.pool_bytes};
      default:              prdata = 32'd0;
    endcase
  end

endmodule

@@ rtl/bba_tree_ram.sv @@
// Single-port busy-bit memory of the allocation tree, registered read.
module bba_tree_ram (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [bba_pkg::NodeW-1:0]  addr_i,
  input  logic                       wdata_i,
  output logic                       rdata_o
);

  logic mem [bba_pkg::TreeNodes];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/bba_engine.sv @@
// Sequencer that scans, marks and releases tree nodes one at a time.
module bba_engine (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bba_pkg::cfg_t              cfg_i,
  input  logic                       start_i,
  input  logic                       mode_i,
  input  logic [23:0]                request_bytes_i,
  input  logic [9:0]                 handle_i,
  output logic                       busy_o,
  output logic                       done_o,
  output logic [1:0]                 status_o,
  output logic [9:0]                 granted_handle_o,
  output logic [24:0]                byte_offset_o,
  output logic [25:0]                block_bytes_o,
  output logic                       mem_we_o,
  output logic [bba_pkg::NodeW-1:0]  mem_addr_o,
  output logic                       mem_wdata_o,
  input  logic                       mem_rdata_i
);

  typedef enum logic [13:0] {
    S_CLEAR     = 14'b00000000000001,
    S_IDLE      = 14'b00000000000010,
    S_CHECK     = 14'b00000000000100,
    S_LEVEL     = 14'b00000000001000,
    S_SCAN_RD   = 14'b00000000010000,
    S_SCAN_CHK  = 14'b00000000100000,
    S_ANC       = 14'b00000001000000,
    S_SUB       = 14'b00000010000000,
    S_MUL       = 14'b00000100000000,
    S_FREE_RD   = 14'b00001000000000,
    S_FREE_CHK  = 14'b00010000000000,
    S_WALK_RD   = 14'b00100000000000,
    S_WALK_CHK  = 14'b01000000000000,
    S_DONE      = 14'b10000000000000
  } state_e;

  localparam int unsigned NW = bba_pkg::NodeW;

  state_e            state_q, state_d;
  logic              mode_q;
  logic [24:0]       size_q;
  logic [NW-1:0]     handle_q;
  logic [25:0]       blk_q, blk_d;
  logic [3:0]        lvl_q, lvl_d, cnt_q, cnt_d;
  logic [NW-1:0]     first_q, first_d, idx_q, idx_d, ptr_q, ptr_d, clr_q, clr_d;
  logic [NW:0]       lo_q, lo_d, hi_q, hi_d, cur_q, cur_d;
  logic              val_q, val_d;
  bba_pkg::status_e  status_q, status_d;
  logic [NW-1:0]     gh_q, gh_d;
  logic [24:0]       off_q, off_d;
  logic [25:0]       bb_q, bb_d;

  logic [3:0]        lvl_eff;
  logic [16:0]       minb_eff;
  logic [NW-1:0]     nodes;
  logic [NW:0]       nodes_w, top, lo_n, hi_n;
  logic [25:0]       max_blk;
  logic [NW-1:0]     buddy, parent;
  logic [35:0]       prod;

  assign lvl_eff  = (cfg_i.levels_in_use > 4'(bba_pkg::MaxLevels - 1))
                    ? 4'(bba_pkg::MaxLevels - 1) : cfg_i.levels_in_use;
  assign minb_eff = (cfg_i.min_block_bytes < 17'(bba_pkg::MinLeaf)) ? 17'(bba_pkg::MinLeaf) :
                    (cfg_i.min_block_bytes > 17'(bba_pkg::MaxLeaf)) ? 17'(bba_pkg::MaxLeaf) :
                    cfg_i.min_block_bytes;
  assign nodes_w  = (NW+1)'(((NW+1)'(1) << (lvl_eff + 4'd1)) - (NW+1)'(1));
  assign nodes    = nodes_w[NW-1:0];
  assign max_blk  = 26'(minb_eff) << lvl_eff;
  assign top      = (hi_q < nodes_w) ? hi_q : nodes_w - (NW+1)'(1);
  assign lo_n     = {lo_q[NW-1:0], 1'b1};
  assign hi_n     = {hi_q[NW-1:0], 1'b0} + (NW+1)'(2);
  assign buddy    = ptr_q[0] ? ptr_q + NW'(1) : ptr_q - NW'(1);
  assign parent   = NW'((ptr_q - NW'(1)) >> 1);
  assign prod     = {26'd0, idx_q - first_q} * {10'd0, blk_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      mode_q   <= mode_i;
      size_q   <= 25'(request_bytes_i) + 25'(bba_pkg::HeaderBytes);
      handle_q <= handle_i;
    end
    blk_q    <= blk_d;
    lvl_q    <= lvl_d;
    cnt_q    <= cnt_d;
    first_q  <= first_d;
    idx_q    <= idx_d;
    ptr_q    <= ptr_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    cur_q    <= cur_d;
    val_q    <= val_d;
    status_q <= status_d;
    gh_q     <= gh_d;
    off_q    <= off_d;
    bb_q     <= bb_d;
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    blk_d       = blk_q;
    lvl_d       = lvl_q;
    cnt_d       = cnt_q;
    first_d     = first_q;
    idx_d       = idx_q;
    ptr_d       = ptr_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    cur_d       = cur_q;
    val_d       = val_q;
    status_d    = status_q;
    gh_d        = gh_q;
    off_d       = off_q;
    bb_d        = bb_q;
    mem_we_o    = 1'b0;
    mem_addr_o  = idx_q;
    mem_wdata_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        mem_we_o   = 1'b1;
        mem_addr_o = clr_q;
        clr_d      = clr_q + NW'(1);
        if (clr_q == NW'(bba_pkg::TreeNodes - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          status_d = bba_pkg::ST_OK;
          gh_d     = '0;
          off_d    = '0;
          bb_d     = '0;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (mode_q) begin
          if (handle_q >= nodes) begin
            status_d = bba_pkg::ST_NOT_BUSY;
            state_d  = S_DONE;
          end else begin
            state_d = S_FREE_RD;
          end
        end else if (26'(size_q) > cfg_i.pool_bytes || 26'(size_q) > max_blk) begin
          status_d = bba_pkg::ST_TOO_BIG;
          state_d  = S_DONE;
        end else begin
          blk_d   = 26'(minb_eff);
          lvl_d   = lvl_eff;
          cnt_d   = '0;
          state_d = S_LEVEL;
        end
      end
      S_LEVEL: begin
        if (cnt_q < lvl_eff && blk_q < 26'(size_q)) begin
          blk_d = blk_q << 1;
          lvl_d = lvl_q - 4'd1;
          cnt_d = cnt_q + 4'd1;
        end else begin
          first_d = NW'(((NW+1)'(1) << lvl_q) - (NW+1)'(1));
          idx_d   = NW'(((NW+1)'(1) << lvl_q) - (NW+1)'(1));
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        mem_addr_o = idx_q;
        state_d    = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (!mem_rdata_i) begin
          ptr_d   = idx_q;
          state_d = S_ANC;
        end else if (idx_q == {first_q[NW-2:0], 1'b0}) begin
          status_d = bba_pkg::ST_NO_MEM;
          state_d  = S_DONE;
        end else begin
          idx_d   = idx_q + NW'(1);
          state_d = S_SCAN_RD;
        end
      end
      S_ANC: begin
        mem_we_o    = 1'b1;
        mem_addr_o  = ptr_q;
        mem_wdata_o = 1'b1;
        if (ptr_q == '0) begin
          lo_d    = {1'b0, idx_q};
          hi_d    = {1'b0, idx_q};
          cur_d   = {1'b0, idx_q};
          val_d   = 1'b1;
          state_d = S_SUB;
        end else begin
          ptr_d = parent;
        end
      end
      S_SUB: begin
        mem_we_o    = 1'b1;
        mem_addr_o  = cur_q[NW-1:0];
        mem_wdata_o = val_q;
        if (cur_q == top) begin
          lo_d = lo_n;
          hi_d = hi_n;
          if (lo_n < nodes_w) begin
            cur_d = lo_n;
          end else if (mode_q) begin
            ptr_d   = handle_q;
            state_d = S_WALK_RD;
          end else begin
            state_d = S_MUL;
          end
        end else begin
          cur_d = cur_q + (NW+1)'(1);
        end
      end
      S_MUL: begin
        gh_d    = idx_q;
        off_d   = prod[24:0] + 25'(bba_pkg::HeaderBytes);
        bb_d    = blk_q;
        state_d = S_DONE;
      end
      S_FREE_RD: begin
        mem_addr_o = handle_q;
        state_d    = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        if (!mem_rdata_i) begin
          status_d = bba_pkg::ST_NOT_BUSY;
          state_d  = S_DONE;
        end else begin
          lo_d    = {1'b0, handle_q};
          hi_d    = {1'b0, handle_q};
          cur_d   = {1'b0, handle_q};
          val_d   = 1'b0;
          state_d = S_SUB;
        end
      end
      S_WALK_RD: begin
        mem_addr_o = buddy;
        if (ptr_q == '0) begin
          state_d = S_DONE;
        end else begin
          state_d = S_WALK_CHK;
        end
      end
      S_WALK_CHK: begin
        if (buddy < nodes && mem_rdata_i) begin
          state_d = S_DONE;
        end else begin
          mem_we_o    = 1'b1;
          mem_addr_o  = parent;
          mem_wdata_o = 1'b0;
          ptr_d       = parent;
          state_d     = S_WALK_RD;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o           = (state_q != S_IDLE);
  assign done_o           = (state_q == S_DONE);
  assign status_o         = status_q;
  assign granted_handle_o = gh_q;
  assign byte_offset_o    = off_q;
  assign block_bytes_o    = bb_q;

endmodule

@@ rtl/buddy_bitmap_allocator.sv @@
// Top level of the buddy bitmap allocator: registers, sequencer and tree store.
// After reset the block sweeps the 1023-entry busy-bit store clear, one node a
// cycle, and holds busy high while it does so. A request is taken when start is
// high and busy low; its single result beat appears for one cycle on done_o and
// cannot be stalled. An allocate checks the request, takes level steps to pick a
// level, scans the nodes on that level (one store read and one check each),
// marks each node from the granted block up to the root and then each subtree
// node, does the offset multiply and gives the result. A free checks the handle,
// reads its busy bit, clears each subtree node, clears the parents on the upward
// walk until a buddy is busy or the root is reached, and gives the result; a
// refused request ends without writing the store. The tree store is single-port,
// so every read or write of a busy bit is a separate step.
module buddy_bitmap_allocator (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         start,
  output logic         busy,
  input  logic         mode_i,
  input  logic [23:0]  request_bytes_i,
  input  logic [9:0]   handle_i,
  output logic         done_o,
  output logic [1:0]   status_o,
  output logic [9:0]   granted_handle_o,
  output logic [24:0]  byte_offset_o,
  output logic [25:0]  block_bytes_o
);

  bba_pkg::cfg_t                cfg;
  logic                         mem_we, mem_wdata, mem_rdata;
  logic [bba_pkg::NodeW-1:0]    mem_addr;

  bba_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bba_tree_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  bba_engine u_eng (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .start_i          (start),
    .mode_i           (mode_i),
    .request_bytes_i  (request_bytes_i),
    .handle_i         (handle_i),
    .busy_o           (busy),
    .done_o           (done_o),
    .status_o         (status_o),
    .granted_handle_o (granted_handle_o),
    .byte_offset_o    (byte_offset_o),
    .block_bytes_o    (block_bytes_o),
    .mem_we_o         (mem_we),
    .mem_addr_o       (mem_addr),
    .mem_wdata_o      (mem_wdata),
    .mem_rdata_i      (mem_rdata)
  );

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted beat did not raise busy");
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result beat while idle");
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result beat repeated");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != bba_pkg::ST_OK) |->
      (granted_handle_o == '0 && byte_offset_o == '0 && block_bytes_o == '0))
    else $error("failed request carries a grant");
`endif

endmodule

@@ tb/buddy_bitmap_allocator_tb.sv @@
// Self-checking testbench for the buddy bitmap allocator: directed and random requests.
module buddy_bitmap_allocator_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;
  localparam int   WatchLimit = 40000;

  typedef struct {
    bba_pkg::status_e status;
    logic [9:0]       granted;
    logic [24:0]      offset;
    logic [25:0]      blk_bytes;
  } grant_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic        mode_i = 1'b0;
  logic [23:0] request_bytes_i = '0;
  logic [9:0]  handle_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [9:0]  granted_handle_o;
  logic [24:0] byte_offset_o;
  logic [25:0] block_bytes_o;

  buddy_bitmap_allocator u_top (.*);

  always #6 clk_i = ~clk_i;

  logic [bba_pkg::TreeNodes-1:0] busy_map;
  logic [3:0]                    cfg_levels;
  logic [16:0]                   cfg_min_blk;
  logic [25:0]                   cfg_pool;
  grant_t                        grant_q[$];
  int                            live_handles[$];
  int                            errors, n_items, n_results, n_ok, n_refused, watch;

  task automatic report(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  function automatic int lv_eff();
    return (cfg_levels > bba_pkg::MaxLevels - 1) ? bba_pkg::MaxLevels - 1 : int'(cfg_levels);
  endfunction

  function automatic longint minb_eff();
    if (cfg_min_blk < bba_pkg::MinLeaf) return bba_pkg::MinLeaf;
    if (cfg_min_blk > bba_pkg::MaxLeaf) return bba_pkg::MaxLeaf;
    return cfg_min_blk;
  endfunction

  task automatic paint_subtree(input int root, input logic v, input int nodes);
    int lo, hi;
    lo = root;
    hi = root;
    while (lo < nodes) begin
      for (int i = lo; i <= ((hi < nodes) ? hi : nodes - 1); i++) busy_map[i] = v;
      lo = 2 * lo + 1;
      hi = 2 * hi + 2;
    end
  endtask

  task automatic predict_grant(input logic md, input logic [23:0] req, input logic [9:0] hdl,
                               output grant_t g);
    int     lv, nodes, lvl, first, idx, up, buddy;
    longint need, blk;
    bit     found;
    g = '{bba_pkg::ST_OK, '0, '0, '0};
    lv = lv_eff();
    nodes = (1 << (lv + 1)) - 1;
    if (md == MODE_ALLOC) begin
      need = longint'(req) + bba_pkg::HeaderBytes;
      blk = minb_eff();
      if (need > cfg_pool || need > (blk << lv)) begin
        g.status = bba_pkg::ST_TOO_BIG;
        return;
      end
      lvl = lv;
      for (int i = 0; i < lv; i++) begin
        if (blk >= need) break;
        blk = blk << 1;
        lvl--;
      end
      first = (1 << lvl) - 1;
      found = 0;
      idx = 0;
      for (int i = first; i < 2 * first + 1; i++) begin
        if (!busy_map[i]) begin
          idx = i;
          found = 1;
          break;
        end
      end
      if (!found) begin
        g.status = bba_pkg::ST_NO_MEM;
        return;
      end
      up = idx;
      busy_map[up] = 1'b1;
      while (up != 0) begin
        up = (up - 1) / 2;
        busy_map[up] = 1'b1;
      end
      paint_subtree(idx, 1'b1, nodes);
      g.granted = idx;
      g.offset = 25'(longint'(idx - first) * blk + bba_pkg::HeaderBytes);
      g.blk_bytes = 26'(blk);
      live_handles.push_back(idx);
    end else begin
      if (hdl >= nodes || !busy_map[hdl]) begin
        g.status = bba_pkg::ST_NOT_BUSY;
        return;
      end
      paint_subtree(hdl, 1'b0, nodes);
      up = hdl;
      while (up != 0) begin
        buddy = up[0] ? up + 1 : up - 1;
        if (buddy < nodes && busy_map[buddy]) break;
        up = (up - 1) / 2;
        busy_map[up] = 1'b0;
      end
      foreach (live_handles[i]) if (live_handles[i] == hdl) begin
        live_handles.delete(i);
        break;
      end
    end
  endtask

  task automatic send_beat(input logic md, input logic [23:0] req, input logic [9:0] hdl);
    grant_t g;
    start <= 1'b1;
    mode_i <= md;
    request_bytes_i <= req;
    handle_i <= hdl;
    do @(posedge clk_i); while (busy);
    predict_grant(md, req, hdl, g);
    grant_q.push_back(g);
    n_items++;
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (grant_q.size() != 0 || busy) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input bba_pkg::reg_idx_e r, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (r)
      bba_pkg::REG_LEVELS:  cfg_levels = v[3:0];
      bba_pkg::REG_MIN_BLK: cfg_min_blk = v[16:0];
      bba_pkg::REG_POOL:    cfg_pool = v[25:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_config(input int lv, input int mb, input int pool);
    drain();
    write_reg(bba_pkg::REG_LEVELS, lv);
    write_reg(bba_pkg::REG_MIN_BLK, mb);
    write_reg(bba_pkg::REG_POOL, pool);
  endtask

  always @(posedge clk_i) begin
    grant_t g;
    if (rst_ni && done_o) begin
      n_results++;
      if (grant_q.size() == 0) begin
        report("result beat with nothing pending");
      end else begin
        g = grant_q.pop_front();
        if (status_o != g.status) report($sformatf("status %0d want %0d", status_o, g.status));
        if (granted_handle_o != g.granted)
          report($sformatf("handle %0d want %0d", granted_handle_o, g.granted));
        if (byte_offset_o != g.offset)
          report($sformatf("offset %0d want %0d", byte_offset_o, g.offset));
        if (block_bytes_o != g.blk_bytes)
          report($sformatf("block %0d want %0d", block_bytes_o, g.blk_bytes));
        if (g.status == bba_pkg::ST_OK) n_ok++;
        else n_refused++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done_o || psel) watch <= 0;
    else watch <= watch + 1;
    if (watch >= WatchLimit) begin
      $display("watchdog expired with %0d results pending", grant_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    send_beat(MODE_ALLOC, 24'd0, 10'd0);
    send_beat(MODE_ALLOC, 24'hFFFFFF, 10'd0);
    send_beat(MODE_ALLOC, 24'd252, 10'd0);
    send_beat(MODE_ALLOC, 24'd4, 10'd0);
    send_beat(MODE_FREE, 24'd0, 10'd1022);
    send_beat(MODE_FREE, 24'd0, 10'd62);
    send_beat(MODE_FREE, 24'hFFFFFF, 10'd31);
    send_beat(MODE_FREE, 24'd0, 10'd0);
    send_beat(MODE_FREE, 24'd0, 10'd0);
    for (int i = 0; i < 3; i++) send_beat(MODE_ALLOC, 24'd124, 10'd0);
    send_beat(MODE_FREE, 24'd0, 10'd1);
    send_beat(MODE_FREE, 24'd0, 10'd2);
    set_config(15, 0, 32'h3FFFFFF);
    send_beat(MODE_ALLOC, 24'd4092, 10'd0);
    send_beat(MODE_ALLOC, 24'd0, 10'd0);
    send_beat(MODE_FREE, 24'd0, 10'd1023);
    send_beat(MODE_FREE, 24'd0, 10'd0);
    set_config(9, 131071, 32'h2000000);
    send_beat(MODE_ALLOC, 24'hFFFFFF, 10'd0);
    send_beat(MODE_ALLOC, 24'd65532, 10'd0);
    send_beat(MODE_FREE, 24'd0, 10'd511);
    set_config(0, 8, 0);
    send_beat(MODE_ALLOC, 24'd0, 10'd0);
    set_config(0, 16, 20);
    send_beat(MODE_ALLOC, 24'd12, 10'd0);
    send_beat(MODE_ALLOC, 24'd0, 10'd0);
  endtask

  task automatic random_config();
    int lv, mb, pool;
    lv = ($urandom_range(9) == 0) ? $urandom_range(15, 8) : $urandom_range(6);
    mb = ($urandom_range(5) == 0) ? $urandom_range(131071) : (1 << $urandom_range(9, 3));
    pool = ($urandom_range(3) == 0) ? $urandom_range(32'h3FFFFFF) : (mb << ((lv > 9) ? 9 : lv));
    set_config(lv, mb, pool);
  endtask

  task automatic test_random_traffic(input int beats, input int idle_pct);
    int        sel, k;
    longint    top;
    logic [9:0] hdl;
    for (int n = 0; n < beats; n++) begin
      if (n % 150 == 0) random_config();
      sel = $urandom_range(99);
      if (sel < 45) begin
        k = $urandom_range(lv_eff());
        top = (minb_eff() << k) - bba_pkg::HeaderBytes;
        send_beat(MODE_ALLOC, 24'($urandom_range(int'(top))), 10'($urandom));
      end else if (sel < 80 && live_handles.size() != 0) begin
        hdl = live_handles[$urandom_range(live_handles.size() - 1)];
        send_beat(MODE_FREE, 24'($urandom), hdl);
      end else if (sel < 90) begin
        send_beat(MODE_ALLOC, 24'($urandom), 10'($urandom));
      end else begin
        send_beat(MODE_FREE, 24'($urandom), 10'($urandom));
      end
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) hold_off($urandom_range(12, 1));
    end
  endtask

  initial begin
    busy_map = '0;
    cfg_levels = 4'd5;
    cfg_min_blk = 17'd8;
    cfg_pool = 26'd256;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_traffic(450, 13);
    test_random_traffic(450, 49);
    test_random_traffic(450, 0);
    drain();
    repeat (50) @(posedge clk_i);
    if (grant_q.size() != 0) report($sformatf("%0d results never arrived", grant_q.size()));
    $display("covered %0d requests, %0d results: %0d granted or freed, %0d refused",
             n_items, n_results, n_ok, n_refused);
    $display("clamped and extreme register settings, ancestor frees, full pools and noise");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
